/* design/wmm_pkg.sv */
// Shared types and constants for the windowed mean and mode unit.
package wmm_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int SUM_BITS     = 24;
    localparam int MEAN_BITS    = 24;
    localparam int FRAC_BITS    = 8;
    localparam int CFG_BITS     = 8;
    localparam int FILL_BITS    = 8;
    localparam int OUT_BITS     = MEAN_BITS + SUM_BITS + SAMPLE_BITS + FILL_BITS;

    // Divider: magnitude of sum shifted up by the fraction bits, one quotient bit a cycle
    localparam int DIV_BITS     = SUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    localparam logic [CFG_BITS-1:0]  WIN_RESET = 8'd16;
    localparam logic [DIV_BITS-1:0]  MAG_LIM   = DIV_BITS'(1) << (MEAN_BITS - 1);
    localparam logic [MEAN_BITS-1:0] MEAN_MAX  = 24'h7F_FFFF;
    localparam logic [MEAN_BITS-1:0] MEAN_MIN  = 24'h80_0000;

    // Command codes carried in tuser
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_UPDATE,
        S_DIV_INIT,
        S_DIV,
        S_MODE_INIT,
        S_MI_RD,
        S_MI_LAT,
        S_MJ,
        S_MJ_TAIL,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic rd_old;
        logic update;
        logic div_init;
        logic div_step;
        logic mode_init;
        logic mi_rd;
        logic mj_init;
        logic mj_issue;
        logic mi_end;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic n_zero;
        logic j_last;
        logic i_last;
    } status_t;

endpackage

/* design/wmm_ctrl.sv */
// Sequencing state machine for the windowed mean and mode unit.
module wmm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_cmd,
    input  logic             out_free,
    input  wmm_pkg::status_t status,
    output logic             in_ready,
    output logic             out_load,
    output wmm_pkg::cmd_t    cmd
);

    wmm_pkg::state_t state_reg;
    wmm_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == wmm_pkg::CMD_CLEAR)
                        state_next = wmm_pkg::S_DONE;
                    else
                        state_next = wmm_pkg::S_RD_OLD;
                end
            end
            wmm_pkg::S_RD_OLD:    state_next = wmm_pkg::S_UPDATE;
            wmm_pkg::S_UPDATE:    state_next = wmm_pkg::S_DIV_INIT;
            wmm_pkg::S_DIV_INIT:  state_next = wmm_pkg::S_DIV;
            wmm_pkg::S_DIV:
            begin
                if (status.div_last)
                    state_next = wmm_pkg::S_MODE_INIT;
            end
            wmm_pkg::S_MODE_INIT:
            begin
                if (status.n_zero)
                    state_next = wmm_pkg::S_DONE;
                else
                    state_next = wmm_pkg::S_MI_RD;
            end
            wmm_pkg::S_MI_RD:     state_next = wmm_pkg::S_MI_LAT;
            wmm_pkg::S_MI_LAT:    state_next = wmm_pkg::S_MJ;
            wmm_pkg::S_MJ:
            begin
                if (status.j_last)
                    state_next = wmm_pkg::S_MJ_TAIL;
            end
            wmm_pkg::S_MJ_TAIL:
            begin
                if (status.i_last)
                    state_next = wmm_pkg::S_DONE;
                else
                    state_next = wmm_pkg::S_MI_RD;
            end
            wmm_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = wmm_pkg::S_IDLE;
            end
            default:              state_next = wmm_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            wmm_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.clear = in_valid && (in_cmd == wmm_pkg::CMD_CLEAR);
                cmd.load  = in_valid && (in_cmd == wmm_pkg::CMD_APPEND);
            end
            wmm_pkg::S_RD_OLD:    cmd.rd_old   = 1'b1;
            wmm_pkg::S_UPDATE:    cmd.update   = 1'b1;
            wmm_pkg::S_DIV_INIT:  cmd.div_init = 1'b1;
            wmm_pkg::S_DIV:       cmd.div_step = 1'b1;
            wmm_pkg::S_MODE_INIT: cmd.mode_init = 1'b1;
            wmm_pkg::S_MI_RD:     cmd.mi_rd    = 1'b1;
            wmm_pkg::S_MI_LAT:    cmd.mj_init  = 1'b1;
            wmm_pkg::S_MJ:        cmd.mj_issue = 1'b1;
            wmm_pkg::S_MJ_TAIL:   cmd.mi_end   = 1'b1;
            wmm_pkg::S_DONE:      out_load     = out_free;
            default:              cmd          = '0;
        endcase
    end

endmodule

/* design/wmm_dp.sv */
// Datapath: sample ring memory, running sum, mean divider and mode search.
module wmm_dp
#(
    parameter int MAX_WINDOW = 255
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [wmm_pkg::CFG_BITS-1:0]             cfg_wdata,
    input  logic signed [wmm_pkg::SAMPLE_BITS-1:0]   in_sample,
    input  wmm_pkg::cmd_t                            cmd,
    output wmm_pkg::status_t                         status,
    output logic signed [wmm_pkg::MEAN_BITS-1:0]     mean,
    output logic signed [wmm_pkg::SUM_BITS-1:0]      window_sum,
    output logic signed [wmm_pkg::SAMPLE_BITS-1:0]   mode_value,
    output logic [wmm_pkg::FILL_BITS-1:0]            fill_count
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [wmm_pkg::CFG_BITS-1:0] MAX_CFG = wmm_pkg::CFG_BITS'(MAX_WINDOW);

    // Configuration and architectural state
    logic [wmm_pkg::CFG_BITS-1:0]            win_reg;
    logic signed [wmm_pkg::SUM_BITS-1:0]     sum_reg;
    logic [AW-1:0]                           pos_reg;
    logic [CW-1:0]                           valid_reg;
    logic [CW-1:0]                           hw_reg;

    // Per-beat working registers
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  sample_reg;
    logic [AW-1:0]                           ptr_reg;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  rdata_reg;
    logic                                    rd_ok_reg;
    logic [wmm_pkg::DIV_BITS-1:0]            dq_reg;
    logic [CW-1:0]                           rem_reg;
    logic                                    neg_reg;
    logic [wmm_pkg::DIV_CNT_BITS-1:0]        dcnt_reg;
    logic signed [wmm_pkg::MEAN_BITS-1:0]    mean_reg;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  cur_reg;
    logic [CW-1:0]                           cnt_reg;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  best_reg;
    logic [CW-1:0]                           bcnt_reg;
    logic [AW-1:0]                           i_reg;
    logic [AW-1:0]                           j_reg;
    logic                                    pend_reg;

    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  mem [MAX_WINDOW];

    logic [wmm_pkg::CFG_BITS-1:0]            eff_full;
    logic [CW-1:0]                           eff;
    logic [CW-1:0]                           n;
    logic [CW-1:0]                           n_m1;
    logic [AW-1:0]                           pos_start;
    logic [AW-1:0]                           rd_addr;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  rd_val;
    logic signed [wmm_pkg::SUM_BITS-1:0]     sum_upd;
    logic [CW-1:0]                           ptr_inc;
    logic [wmm_pkg::SUM_BITS-1:0]            sum_mag;
    logic [CW:0]                             div_sh;
    logic [CW:0]                             div_diff;
    logic                                    div_ge;
    logic signed [wmm_pkg::MEAN_BITS-1:0]    mean_fin;
    logic                                    match;
    logic [CW-1:0]                           cnt_fin;
    logic                                    take_best;

    // Effective window: zero acts as one, clamp at the ring depth
    always_comb
    begin
        if (win_reg == '0)
            eff_full = wmm_pkg::CFG_BITS'(1);
        else if (win_reg > MAX_CFG)
            eff_full = MAX_CFG;
        else
            eff_full = win_reg;
        eff  = eff_full[CW-1:0];
        n    = (valid_reg < eff) ? valid_reg : eff;
        n_m1 = n - CW'(1);
    end

    assign pos_start = (CW'(pos_reg) >= eff) ? '0 : pos_reg;

    // Entries past the high-water mark were never written since clear and read as zero
    assign rd_val = rd_ok_reg ? rdata_reg : '0;

    // Append arithmetic
    assign sum_upd = sum_reg - wmm_pkg::SUM_BITS'(rd_val) + wmm_pkg::SUM_BITS'(sample_reg);
    assign ptr_inc = CW'(ptr_reg) + CW'(1);

    // Restoring divider step
    assign sum_mag  = sum_reg[wmm_pkg::SUM_BITS-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign div_sh   = {rem_reg, dq_reg[wmm_pkg::DIV_BITS-1]};
    assign div_diff = div_sh - {1'b0, eff};
    assign div_ge   = (div_sh >= {1'b0, eff});

    // Quotient sign and saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (dq_reg > wmm_pkg::MAG_LIM)
                mean_fin = wmm_pkg::MEAN_MIN;
            else
                mean_fin = -dq_reg[wmm_pkg::MEAN_BITS-1:0];
        end
        else
        begin
            if (dq_reg >= wmm_pkg::MAG_LIM)
                mean_fin = wmm_pkg::MEAN_MAX;
            else
                mean_fin = dq_reg[wmm_pkg::MEAN_BITS-1:0];
        end
    end

    // Mode compare: last count includes the beat still in flight
    assign match     = pend_reg && (rd_val == cur_reg);
    assign cnt_fin   = cnt_reg + CW'(match);
    assign take_best = (cnt_fin > bcnt_reg) || ((cnt_fin == bcnt_reg) && (cur_reg < best_reg));

    // Memory read address
    always_comb
    begin
        if (cmd.rd_old)
            rd_addr = ptr_reg;
        else if (cmd.mi_rd)
            rd_addr = i_reg;
        else
            rd_addr = j_reg;
    end

    // Sample ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            mem[ptr_reg] <= sample_reg;
        rdata_reg <= mem[rd_addr];
        rd_ok_reg <= (CW'(rd_addr) < hw_reg);
    end

    // Window size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= wmm_pkg::WIN_RESET;
        else if (cfg_we)
            win_reg <= cfg_wdata;
    end

    // Running sum, write position, fill count, high-water mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            pos_reg   <= '0;
            valid_reg <= '0;
            hw_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            sum_reg   <= '0;
            pos_reg   <= '0;
            valid_reg <= '0;
            hw_reg    <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg   <= sum_upd;
            pos_reg   <= (ptr_inc >= eff) ? '0 : ptr_inc[AW-1:0];
            valid_reg <= (valid_reg < eff) ? (valid_reg + CW'(1)) : eff;
            if (ptr_inc > hw_reg)
                hw_reg <= ptr_inc;
        end
    end

    // Beat capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= in_sample;
            ptr_reg    <= pos_start;
        end
    end

    // Mean divider
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg  <= sum_reg[wmm_pkg::SUM_BITS-1];
            dq_reg   <= {sum_mag, wmm_pkg::FRAC_BITS'(0)};
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? div_diff[CW-1:0] : div_sh[CW-1:0];
            dq_reg   <= {dq_reg[wmm_pkg::DIV_BITS-2:0], div_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // Mean result and mode search
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mean_reg <= '0;
            best_reg <= '0;
        end
        else if (cmd.mode_init)
        begin
            mean_reg <= mean_fin;
            best_reg <= '0;
            bcnt_reg <= '0;
            i_reg    <= '0;
        end
        else if (cmd.mj_init)
        begin
            cur_reg  <= rd_val;
            cnt_reg  <= '0;
            j_reg    <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.mj_issue)
        begin
            cnt_reg  <= cnt_fin;
            j_reg    <= j_reg + 1'b1;
            pend_reg <= 1'b1;
        end
        else if (cmd.mi_end)
        begin
            if (take_best)
            begin
                best_reg <= cur_reg;
                bcnt_reg <= cnt_fin;
            end
            i_reg    <= i_reg + 1'b1;
            pend_reg <= 1'b0;
        end
    end

    // Status to controller
    assign status.div_last = (dcnt_reg == wmm_pkg::DIV_CNT_BITS'(wmm_pkg::DIV_BITS - 1));
    assign status.n_zero   = (n == '0);
    assign status.j_last   = (CW'(j_reg) == n_m1);
    assign status.i_last   = (CW'(i_reg) == n_m1);

    // Results
    assign mean       = mean_reg;
    assign window_sum = sum_reg;
    assign mode_value = best_reg;
    assign fill_count = wmm_pkg::FILL_BITS'(valid_reg);

endmodule

/* design/windowed_mean_and_mode_unit.sv */
// Top level of the windowed mean and mode unit: controller, datapath, output register.
//
// Moving average over a ring of signed 16-bit samples with the mode of the filled
// entries. Each input beat (tuser = 0 append, 1 clear) yields one result beat with the
// mean (sum * 256 / window, truncated toward zero, saturated), the running sum, the
// mode (smallest value on ties, 0 when empty) and the fill count. An append runs the
// bit-serial mean divider, then a pairwise count over the ring through its single read
// port, one compare per cycle. One beat is worked on at a time; a new beat is taken
// while the previous result still waits in the output register. The user must write
// window_size with cfg_we only while the unit is idle; the unit does not enforce it.
module windowed_mean_and_mode_unit
#(
    parameter int MAX_WINDOW = 255
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: window_size
    input  logic                             cfg_we,
    input  logic [wmm_pkg::CFG_BITS-1:0]     cfg_wdata,
    // input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] sample
    input  logic [0:0]                       s_tuser,   // [0] cmd
    // result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wmm_pkg::OUT_BITS-1:0]     m_tdata    // mean, window_sum, mode_value, fill_count
);

    wmm_pkg::cmd_t                           cmd;
    wmm_pkg::status_t                        status;
    logic                                    out_load;
    logic                                    out_free;
    logic signed [wmm_pkg::MEAN_BITS-1:0]    mean;
    logic signed [wmm_pkg::SUM_BITS-1:0]     window_sum;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0]  mode_value;
    logic [wmm_pkg::FILL_BITS-1:0]           fill_count;
    logic                                    m_tvalid_reg;
    logic [wmm_pkg::OUT_BITS-1:0]            m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    wmm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    wmm_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_sample  (s_tdata[wmm_pkg::SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .status     (status),
        .mean       (mean),
        .window_sum (window_sum),
        .mode_value (mode_value),
        .fill_count (fill_count)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {fill_count, mode_value, window_sum, mean};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* design/wmm_checker.sv */
// Port-level checks for the windowed mean and mode unit, bound to the top level.
module wmm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wmm_pkg::OUT_BITS-1:0]  m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An accepted append keeps the input closed for the next cycle
    a_append_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == wmm_pkg::CMD_APPEND) |=> !s_tready)
        else $error("input open right after an append");

    // An empty window reports all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[71:64] == '0) |-> (m_tdata[63:0] == '0))
        else $error("empty window with nonzero result");

    // A new result appears only out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised without work in progress");

endmodule

bind windowed_mean_and_mode_unit wmm_checker u_wmm_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the windowed mean and mode unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 255;

    // One result beat, split into its fields
    typedef struct packed {
        logic signed [wmm_pkg::MEAN_BITS-1:0]   mean;
        logic signed [wmm_pkg::SUM_BITS-1:0]    total;
        logic signed [wmm_pkg::SAMPLE_BITS-1:0] mode;
        logic [wmm_pkg::FILL_BITS-1:0]          fill;
    } window_stats_t;

    localparam window_stats_t ZERO_STATS = '0;

    // One row of the directed table: either a window size write or an input beat
    typedef struct packed {
        bit                                     set_window;
        logic [wmm_pkg::CFG_BITS-1:0]           window;
        logic                                   cmd;
        logic signed [wmm_pkg::SAMPLE_BITS-1:0] smp;
        bit                                     typed;
        window_stats_t                          want;
    } stim_row_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [wmm_pkg::CFG_BITS-1:0] cfg_wdata = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [15:0]                  s_tdata   = '0;   // [15:0] sample
    logic [0:0]                   s_tuser   = '0;   // [0] cmd
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [wmm_pkg::OUT_BITS-1:0] m_tdata;          // mean, window_sum, mode_value, fill_count

    // Shadow copy of the unit's state and register
    logic [wmm_pkg::CFG_BITS-1:0]           win_reg = wmm_pkg::WIN_RESET;
    logic signed [wmm_pkg::SAMPLE_BITS-1:0] ring [RING_DEPTH];
    longint                                 acc_sum  = 0;
    int                                     wr_pos   = 0;
    int                                     fill_cnt = 0;

    window_stats_t pending_stats [$];
    int  error_count     = 0;
    int  results_checked = 0;
    int  appends_sent    = 0;
    int  clears_sent     = 0;
    int  settings_used   = 0;
    bit  in_stalls       = 1'b1;
    bit  out_stalls      = 1'b1;

    // Directed part: reset state, extremes, ties, shrink cases, window 0 and 255
    stim_row_t directed_rows [28] = '{
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd0, 1'b1, '{24'sd0, 24'sd0, 16'sd0, 8'd1}},
        '{1'b0, 8'd0, wmm_pkg::CMD_CLEAR, 16'shFFFF, 1'b1, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b1,
          '{24'sd524272, 24'sd32767, 16'sd32767, 8'd1}},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b1,
          '{-24'sd16, -24'sd1, 16'sh8000, 8'd2}},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        // shrink below the write position and fill count, stale entries saturate the mean
        '{1'b1, 8'd2, wmm_pkg::CMD_APPEND, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd32767, 1'b0, ZERO_STATS},
        '{1'b1, 8'd1, wmm_pkg::CMD_APPEND, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        // negative saturation with window 0 read as 1
        '{1'b1, 8'd8, wmm_pkg::CMD_APPEND, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_CLEAR, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b0, ZERO_STATS},
        '{1'b1, 8'd0, wmm_pkg::CMD_APPEND, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sh8000, 1'b1,
          '{wmm_pkg::MEAN_MIN, -24'sd131072, 16'sh8000, 8'd1}},
        // largest window, kept short
        '{1'b1, 8'd255, wmm_pkg::CMD_APPEND, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_CLEAR, 16'sd0, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd1, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd2, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, 16'sd2, 1'b0, ZERO_STATS},
        '{1'b0, 8'd0, wmm_pkg::CMD_APPEND, -16'sd3, 1'b0, ZERO_STATS}
    };

    windowed_mean_and_mode_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("timeout: %0d results still outstanding", pending_stats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Apply one command to the shadow window and return the stats it produces
    function automatic window_stats_t window_stats_after(input logic cmd,
                                                         input logic signed [15:0] smp);
        window_stats_t                          res;
        int                                     sz;
        int                                     p;
        int                                     n;
        int                                     hits;
        int                                     best_hits;
        logic signed [wmm_pkg::SAMPLE_BITS-1:0] best;
        logic signed [wmm_pkg::SUM_BITS-1:0]    wrapped;
        longint                                 q;
        res = ZERO_STATS;
        sz = (win_reg == '0) ? 1 : int'(win_reg);
        if (cmd == wmm_pkg::CMD_CLEAR)
        begin
            foreach (ring[k])
                ring[k] = '0;
            acc_sum  = 0;
            wr_pos   = 0;
            fill_cnt = 0;
            return res;
        end
        // position past a shrunken window wraps to entry 0
        p = (wr_pos >= sz) ? 0 : wr_pos;
        acc_sum = acc_sum - longint'(ring[p]) + longint'(smp);
        ring[p] = smp;
        wrapped = acc_sum[wmm_pkg::SUM_BITS-1:0];
        acc_sum = longint'(wrapped);
        p++;
        wr_pos   = (p >= sz) ? 0 : p;
        fill_cnt = (fill_cnt < sz) ? fill_cnt + 1 : sz;
        // mean in 8 fraction bits, truncated toward zero, saturated
        q = (acc_sum * 256) / longint'(sz);
        if (q > 64'sd8388607)
            q = 64'sd8388607;
        if (q < -64'sd8388608)
            q = -64'sd8388608;
        // mode over the filled entries, smallest value on ties
        n = (fill_cnt < sz) ? fill_cnt : sz;
        best = '0;
        best_hits = 0;
        for (int i = 0; i < n; i++)
        begin
            hits = 0;
            for (int j = 0; j < n; j++)
                if (ring[j] == ring[i])
                    hits++;
            if (hits > best_hits || (hits == best_hits && ring[i] < best))
            begin
                best_hits = hits;
                best = ring[i];
            end
        end
        res.mean  = q[wmm_pkg::MEAN_BITS-1:0];
        res.total = wrapped;
        res.mode  = best;
        res.fill  = fill_cnt[wmm_pkg::FILL_BITS-1:0];
        return res;
    endfunction

    // Drive one input beat and record its expected stats once accepted
    task automatic push_beat(input logic cmd, input logic signed [15:0] smp,
                             input bit typed, input window_stats_t typed_want);
        window_stats_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted = window_stats_after(cmd, smp);
        pending_stats.push_back(typed ? typed_want : predicted);
        if (cmd == wmm_pkg::CMD_CLEAR)
            clears_sent++;
        else
            appends_sent++;
    endtask

    // Random gap on the input side
    task automatic pause_input();
        if (in_stalls && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Window size write, only once every outstanding result has drained
    task automatic load_window(input logic [wmm_pkg::CFG_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_reg = value;
        settings_used++;
    endtask

    // Result side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_stalls && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_results
        window_stats_t got;
        window_stats_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.mean  = m_tdata[0 +: wmm_pkg::MEAN_BITS];
            got.total = m_tdata[wmm_pkg::MEAN_BITS +: wmm_pkg::SUM_BITS];
            got.mode  = m_tdata[wmm_pkg::MEAN_BITS + wmm_pkg::SUM_BITS +: wmm_pkg::SAMPLE_BITS];
            got.fill  = m_tdata[wmm_pkg::OUT_BITS - wmm_pkg::FILL_BITS +: wmm_pkg::FILL_BITS];
            results_checked++;
            if (pending_stats.size() == 0)
                report_mismatch($sformatf("result beat %0d with nothing expected",
                                          results_checked));
            else
            begin
                want = pending_stats.pop_front();
                if (got.mean !== want.mean)
                    report_mismatch($sformatf("beat %0d mean got %0d expected %0d",
                                              results_checked, got.mean, want.mean));
                if (got.total !== want.total)
                    report_mismatch($sformatf("beat %0d window_sum got %0d expected %0d",
                                              results_checked, got.total, want.total));
                if (got.mode !== want.mode)
                    report_mismatch($sformatf("beat %0d mode_value got %0d expected %0d",
                                              results_checked, got.mode, want.mode));
                if (got.fill !== want.fill)
                    report_mismatch($sformatf("beat %0d fill_count got %0d expected %0d",
                                              results_checked, got.fill, want.fill));
            end
        end
    end

    // Reset, directed table, then random phases
    initial
    begin : stimulus
        logic signed [wmm_pkg::SAMPLE_BITS-1:0] palette [4];
        logic signed [wmm_pkg::SAMPLE_BITS-1:0] smp;
        logic                                   cmd;
        int                                     pick;
        foreach (ring[k])
            ring[k] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].set_window)
                load_window(directed_rows[r].window);
            else
            begin
                push_beat(directed_rows[r].cmd, directed_rows[r].smp,
                          directed_rows[r].typed, directed_rows[r].want);
                pause_input();
            end
        end

        // Each phase picks a window size without clearing, so stale entries carry over
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 4)
            begin
                in_stalls  = 1'b0;
                out_stalls = 1'b0;
            end
            load_window((phase == 2) ? wmm_pkg::CFG_BITS'($urandom_range(20, 48))
                                     : wmm_pkg::CFG_BITS'($urandom_range(0, 12)));
            foreach (palette[k])
                palette[k] = wmm_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
            repeat (20)
            begin
                pick = $urandom_range(0, 99);
                cmd  = (pick < 7) ? wmm_pkg::CMD_CLEAR : wmm_pkg::CMD_APPEND;
                if (pick < 55)
                    smp = palette[$urandom_range(0, 3)];
                else if (pick < 85)
                    smp = wmm_pkg::SAMPLE_BITS'($urandom_range(0, 65535));
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       smp = 16'sh8000;
                        1:       smp = 16'sh7FFF;
                        2:       smp = 16'sh0000;
                        default: smp = 16'shFFFF;
                    endcase
                end
                push_beat(cmd, smp, 1'b0, ZERO_STATS);
                pause_input();
            end
        end

        // Drain, then watch for stray beats
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d appends and %0d clears across %0d window size writes.",
                 appends_sent, clears_sent, settings_used);
        $display("Checked %0d result beats, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
